// ===== hw/rtl/earot_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// earot_pkg
// Shared widths, types, CORDIC constants and the Q.30 product helper for the
// ZXZ Euler-angle vector rotation unit.
// ----------------------------------------------------------------------------
package earot_pkg;

   localparam int VEC_WIDTH    = 32;
   localparam int ANGLE_WIDTH  = 16;
   localparam int TRIG_FRAC    = 30;
   localparam int CORDIC_STEPS = 30;
   localparam int ANGLE_SHIFT  = TRIG_FRAC - (ANGLE_WIDTH - 3);

   localparam int Z_W    = 35;
   localparam int XY_W   = 34;
   localparam int TRIG_W = 32;
   localparam int ELEM_W = 33;
   localparam int PROD_W = VEC_WIDTH + ELEM_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int RND_W  = SUM_W - TRIG_FRAC;

   localparam int LANE_DEPTH  = CORDIC_STEPS + 1;
   localparam int MERGE_DEPTH = 4;
   localparam int PIPE_DEPTH  = LANE_DEPTH + MERGE_DEPTH;

   typedef logic signed [VEC_WIDTH-1:0]   vec_type;
   typedef logic signed [ANGLE_WIDTH-1:0] angle_type;
   typedef logic signed [TRIG_W-1:0]      trig_type;
   typedef logic signed [ELEM_W-1:0]      elem_type;
   typedef logic signed [XY_W-1:0]        xy_type;
   typedef logic signed [Z_W-1:0]         z_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [SUM_W-1:0]       sum_type;
   typedef logic signed [RND_W-1:0]       rnd_type;

   localparam xy_type CORDIC_START = 34'sd652032874;
   localparam z_type  HALF_PI      = 35'sd1686629713;
   localparam z_type  PI           = 35'sd3373259426;

   localparam logic signed [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
      32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
      32'sd67021686,  32'sd33543515,  32'sd16775850,  32'sd8388437,
      32'sd4194282,   32'sd2097149,   32'sd1048575,   32'sd524287,
      32'sd262143,    32'sd131071,    32'sd65535,     32'sd32767,
      32'sd16383,     32'sd8191,      32'sd4095,      32'sd2047,
      32'sd1023,      32'sd511,       32'sd255,       32'sd127,
      32'sd63,        32'sd31,        32'sd15,        32'sd7,
      32'sd3,         32'sd1
   };

   // floor(a*b / 2^30); operands are unit-range trig values
   function automatic trig_type qmul(trig_type a, trig_type b);
      logic signed [2*TRIG_W-1:0] p;
      p = a * b;
      return $signed(p[TRIG_FRAC+TRIG_W-1:TRIG_FRAC]);
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/euler_angle_vector_rotation_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// euler_angle_vector_rotation_unit
// ZXZ Euler-angle rotation of a Q16.16 vector: three CORDIC lanes form the
// sines and cosines, a merge stage builds the matrix and rotates the vector.
// ----------------------------------------------------------------------------
//   channel  direction  handshake          payload
//   req_     in         req_valid/stall    in_x, in_y, in_z, theta, phi, psi
//   rsp_     out        rsp_valid/stall    out_x, out_y, out_z, saturated
//
// One beat per cycle while the pipeline is not frozen; 31 CORDIC lane stages
// plus 4 merge stages: two product stages, element multiply, round/clamp.
// The whole pipeline advances together; it freezes only while a finished
// beat sits in the output register and rsp_stall is high.
// A one-entry skid register takes a request beat during a freeze, so
// req_stall is a register output. Synchronous reset clears valid bits only.
// ----------------------------------------------------------------------------
module euler_angle_vector_rotation_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire earot_pkg::vec_type   req_in_x,
   input  wire earot_pkg::vec_type   req_in_y,
   input  wire earot_pkg::vec_type   req_in_z,
   input  wire earot_pkg::angle_type req_theta,
   input  wire earot_pkg::angle_type req_phi,
   input  wire earot_pkg::angle_type req_psi,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output earot_pkg::vec_type        rsp_out_x,
   output earot_pkg::vec_type        rsp_out_y,
   output earot_pkg::vec_type        rsp_out_z,
   output logic                      rsp_saturated
);
   import earot_pkg::*;

   logic      advance;
   logic      accept;
   logic      src_valid;

   // skid entry
   logic      skid_vld_ff;
   vec_type   skid_x_ff, skid_y_ff, skid_z_ff;
   angle_type skid_theta_ff, skid_phi_ff, skid_psi_ff;

   // beat presented to the pipeline head
   vec_type   src_x, src_y, src_z;
   angle_type src_theta, src_phi, src_psi;

   logic      vld_ff [PIPE_DEPTH];
   vec_type   vx_ff  [LANE_DEPTH];
   vec_type   vy_ff  [LANE_DEPTH];
   vec_type   vz_ff  [LANE_DEPTH];

   trig_type  st, ct, sp, cp, ss, cs;

   // freeze only when the output register holds an untaken beat
   assign advance   = !(vld_ff[PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = skid_vld_ff;
   assign accept    = req_valid && !skid_vld_ff;
   assign src_valid = skid_vld_ff || accept;

   always_comb begin
      if (skid_vld_ff) begin
         src_x = skid_x_ff;  src_y = skid_y_ff;  src_z = skid_z_ff;
         src_theta = skid_theta_ff;  src_phi = skid_phi_ff;  src_psi = skid_psi_ff;
      end else begin
         src_x = req_in_x;  src_y = req_in_y;  src_z = req_in_z;
         src_theta = req_theta;  src_phi = req_phi;  src_psi = req_psi;
      end
   end

   // park a beat taken during a freeze; drain it on the next advance
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (advance) begin
         skid_vld_ff <= 1'b0;
      end else if (accept) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!advance && accept) begin
         skid_x_ff     <= req_in_x;
         skid_y_ff     <= req_in_y;
         skid_z_ff     <= req_in_z;
         skid_theta_ff <= req_theta;
         skid_phi_ff   <= req_phi;
         skid_psi_ff   <= req_psi;
      end
   end

   // valid bits follow the beats through every stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= src_valid;
         for (int k = 1; k < PIPE_DEPTH; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // hold the vector alongside the CORDIC lanes
   always_ff @(posedge clock) begin
      if (advance) begin
         vx_ff[0] <= src_x;
         vy_ff[0] <= src_y;
         vz_ff[0] <= src_z;
         for (int k = 1; k < LANE_DEPTH; k++) begin
            vx_ff[k] <= vx_ff[k-1];
            vy_ff[k] <= vy_ff[k-1];
            vz_ff[k] <= vz_ff[k-1];
         end
      end
   end

   earot_cordic_lane u_lane_theta (
      .clock   (clock),
      .advance (advance),
      .angle   (src_theta),
      .sin_out (st),
      .cos_out (ct)
   );

   earot_cordic_lane u_lane_phi (
      .clock   (clock),
      .advance (advance),
      .angle   (src_phi),
      .sin_out (sp),
      .cos_out (cp)
   );

   earot_cordic_lane u_lane_psi (
      .clock   (clock),
      .advance (advance),
      .angle   (src_psi),
      .sin_out (ss),
      .cos_out (cs)
   );

   earot_merge u_merge (
      .clock     (clock),
      .advance   (advance),
      .st        (st),
      .ct        (ct),
      .sp        (sp),
      .cp        (cp),
      .ss        (ss),
      .cs        (cs),
      .vec_x     (vx_ff[LANE_DEPTH-1]),
      .vec_y     (vy_ff[LANE_DEPTH-1]),
      .vec_z     (vz_ff[LANE_DEPTH-1]),
      .out_x     (rsp_out_x),
      .out_y     (rsp_out_y),
      .out_z     (rsp_out_z),
      .saturated (rsp_saturated)
   );

   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

endmodule
`default_nettype wire

// ===== hw/rtl/earot_cordic_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// earot_cordic_lane
// One angle lane: quadrant fold, then a 30-stage pipelined rotation CORDIC
// giving sine and cosine in Q2.30.
// ----------------------------------------------------------------------------
module earot_cordic_lane (
   input  wire logic                 clock,
   input  wire logic                 advance,
   input  wire earot_pkg::angle_type angle,
   output earot_pkg::trig_type       sin_out,
   output earot_pkg::trig_type       cos_out
);
   import earot_pkg::*;

   xy_type x_ff   [LANE_DEPTH];
   xy_type y_ff   [LANE_DEPTH];
   z_type  z_ff   [CORDIC_STEPS];
   logic   neg_ff [LANE_DEPTH];

   z_type  z_ext;
   z_type  z_in;
   logic   neg_in;
   xy_type x_neg;
   xy_type y_neg;

   // fold angles beyond +-pi/2 by pi; flip the signs at the end
   always_comb begin
      z_ext  = z_type'(angle) <<< ANGLE_SHIFT;
      z_in   = z_ext;
      neg_in = 1'b0;
      if (z_ext > HALF_PI) begin
         z_in   = z_ext - PI;
         neg_in = 1'b1;
      end else if (z_ext < -HALF_PI) begin
         z_in   = z_ext + PI;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]   <= CORDIC_START;
         y_ff[0]   <= '0;
         z_ff[0]   <= z_in;
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      xy_type xs;
      xy_type ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (advance) begin
            if (!z_ff[i][Z_W-1]) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
            end
            neg_ff[i+1] <= neg_ff[i];
         end
      end

      if (i < CORDIC_STEPS - 1) begin : g_angle
         always_ff @(posedge clock) begin
            if (advance) begin
               if (!z_ff[i][Z_W-1]) begin
                  z_ff[i+1] <= z_ff[i] - z_type'(ATAN_TABLE[i]);
               end else begin
                  z_ff[i+1] <= z_ff[i] + z_type'(ATAN_TABLE[i]);
               end
            end
         end
      end
   end

   assign x_neg   = -x_ff[LANE_DEPTH-1];
   assign y_neg   = -y_ff[LANE_DEPTH-1];
   assign cos_out = neg_ff[LANE_DEPTH-1] ? $signed(x_neg[TRIG_W-1:0])
                                         : $signed(x_ff[LANE_DEPTH-1][TRIG_W-1:0]);
   assign sin_out = neg_ff[LANE_DEPTH-1] ? $signed(y_neg[TRIG_W-1:0])
                                         : $signed(y_ff[LANE_DEPTH-1][TRIG_W-1:0]);

endmodule
`default_nettype wire

// ===== hw/rtl/earot_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// earot_merge
// Combine the three lanes: trig products, ZXZ matrix, matrix-vector product,
// rounding and saturation. Four register stages, the last is the output.
// ----------------------------------------------------------------------------
module earot_merge (
   input  wire logic                clock,
   input  wire logic                advance,
   input  wire earot_pkg::trig_type st,
   input  wire earot_pkg::trig_type ct,
   input  wire earot_pkg::trig_type sp,
   input  wire earot_pkg::trig_type cp,
   input  wire earot_pkg::trig_type ss,
   input  wire earot_pkg::trig_type cs,
   input  wire earot_pkg::vec_type  vec_x,
   input  wire earot_pkg::vec_type  vec_y,
   input  wire earot_pkg::vec_type  vec_z,
   output earot_pkg::vec_type       out_x,
   output earot_pkg::vec_type       out_y,
   output earot_pkg::vec_type       out_z,
   output logic                     saturated
);
   import earot_pkg::*;

   // stage 1: first products
   trig_type spct_ff, cpct_ff, cpcs_ff, cpss_ff, spcs_ff, spss_ff;
   trig_type stsp_ff, stcp_ff, stss_ff, stcs_ff, ct1_ff, ss1_ff, cs1_ff;
   vec_type  v1_ff [3];
   // stage 2: matrix
   elem_type m_ff  [9];
   vec_type  v2_ff [3];
   // stage 3: element products
   prod_type p_ff  [9];
   // stage 4: output
   vec_type  o_ff  [3];
   logic     sat_ff;

   elem_type m_in  [9];
   vec_type  o_in  [3];
   logic     sat_in;

   always_ff @(posedge clock) begin
      if (advance) begin
         spct_ff <= qmul(sp, ct);
         cpct_ff <= qmul(cp, ct);
         cpcs_ff <= qmul(cp, cs);
         cpss_ff <= qmul(cp, ss);
         spcs_ff <= qmul(sp, cs);
         spss_ff <= qmul(sp, ss);
         stsp_ff <= qmul(st, sp);
         stcp_ff <= qmul(st, cp);
         stss_ff <= qmul(st, ss);
         stcs_ff <= qmul(st, cs);
         ct1_ff  <= ct;
         ss1_ff  <= ss;
         cs1_ff  <= cs;
         v1_ff[0] <= vec_x;
         v1_ff[1] <= vec_y;
         v1_ff[2] <= vec_z;
      end
   end

   always_comb begin
      m_in[0] = elem_type'(cpcs_ff) - elem_type'(qmul(spct_ff, ss1_ff));
      m_in[1] = -elem_type'(cpss_ff) - elem_type'(qmul(spct_ff, cs1_ff));
      m_in[2] = elem_type'(stsp_ff);
      m_in[3] = elem_type'(spcs_ff) + elem_type'(qmul(cpct_ff, ss1_ff));
      m_in[4] = -elem_type'(spss_ff) + elem_type'(qmul(cpct_ff, cs1_ff));
      m_in[5] = -elem_type'(stcp_ff);
      m_in[6] = elem_type'(stss_ff);
      m_in[7] = elem_type'(stcs_ff);
      m_in[8] = elem_type'(ct1_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_ff  <= m_in;
         v2_ff <= v1_ff;
      end
   end

   for (genvar k = 0; k < 9; k++) begin : g_prod
      always_ff @(posedge clock) begin
         if (advance) begin
            p_ff[k] <= prod_type'(m_ff[k]) * prod_type'(v2_ff[k % 3]);
         end
      end
   end

   // round half up, then clamp to the vector width
   always_comb begin
      sum_type sum;
      rnd_type rnd;
      sat_in = 1'b0;
      for (int r = 0; r < 3; r++) begin
         sum = sum_type'(p_ff[3*r]) + sum_type'(p_ff[3*r+1]) + sum_type'(p_ff[3*r+2])
             + (sum_type'(1) <<< (TRIG_FRAC - 1));
         rnd = $signed(sum[SUM_W-1:TRIG_FRAC]);
         if (rnd[RND_W-1:VEC_WIDTH-1] == '0 || rnd[RND_W-1:VEC_WIDTH-1] == '1) begin
            o_in[r] = $signed(rnd[VEC_WIDTH-1:0]);
         end else begin
            o_in[r] = rnd[RND_W-1] ? $signed({1'b1, {(VEC_WIDTH-1){1'b0}}})
                                   : $signed({1'b0, {(VEC_WIDTH-1){1'b1}}});
            sat_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         o_ff   <= o_in;
         sat_ff <= sat_in;
      end
   end

   assign out_x     = o_ff[0];
   assign out_y     = o_ff[1];
   assign out_z     = o_ff[2];
   assign saturated = sat_ff;

endmodule
`default_nettype wire
